/* design/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, character codes and helper functions of the text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int LINE_BITS  = 24;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LE    = 8'h65;

  typedef enum logic [3:0] {
    MODE_BLANK,
    MODE_LOOK,
    MODE_HASH,
    MODE_HASHGT,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING
  } mode_t;

  typedef enum logic [3:0] {
    TK_EOF    = 4'd0,
    TK_IDENT  = 4'd1,
    TK_STRING = 4'd2,
    TK_NUMBER = 4'd3,
    TK_LPAREN = 4'd4,
    TK_RPAREN = 4'd5,
    TK_LBRACK = 4'd6,
    TK_RBRACK = 4'd7,
    TK_LBRACE = 4'd8,
    TK_RBRACE = 4'd9,
    TK_LANGLE = 4'd10,
    TK_RANGLE = 4'd11
  } tkind_t;

  typedef struct packed {
    tkind_t     kind;
    logic       has_char;
    logic [7:0] ch;
    logic       first;
    logic       done;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                 two;
    logic [LINE_BITS-1:0] line;
    result_t              r1;
    result_t              r0;
  } entry_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic tkind_t bracket_kind(input logic [7:0] c);
    tkind_t k;
    case (c)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h5B:   k = TK_LBRACK;
      8'h5D:   k = TK_RBRACK;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h3C:   k = TK_LANGLE;
      8'h3E:   k = TK_RANGLE;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic result_t mk_res(input tkind_t kind, input logic has_char,
                                     input logic [7:0] ch, input logic first,
                                     input logic done);
    result_t r;
    r.kind     = kind;
    r.has_char = has_char;
    r.ch       = has_char ? ch : 8'h00;
    r.first    = first;
    r.done     = done;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

/* design/ctt_lexer.sv */
// ----------------------------------------------------------------------------
// ctt_lexer
// Lexer mode, line counter and per-transaction result decode.
// ----------------------------------------------------------------------------
module ctt_lexer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            kind,
  input  logic [7:0]      text_byte,
  output logic            push,
  output ctt_pkg::entry_t entry
);

  ctt_pkg::mode_t                 mode_r, mode_nxt;
  logic                           pend_r, pend_nxt;
  logic [ctt_pkg::LINE_BITS-1:0]  line_r, line_nxt;

  ctt_pkg::tkind_t  bk;
  logic             st_emit;
  ctt_pkg::result_t st_res;
  ctt_pkg::mode_t   st_mode;
  logic             st_setp;
  logic             is_blank;
  logic             is_lf;
  logic             ident_ch;
  logic             num_ch;

  logic             bump;
  logic             e0_v, e1_v;
  ctt_pkg::result_t r0, r1;

  assign is_blank = (text_byte <= ctt_pkg::CH_SPACE);
  assign is_lf    = (text_byte == ctt_pkg::CH_LF);
  assign ident_ch = ctt_pkg::is_letter(text_byte) || ctt_pkg::is_digit(text_byte) ||
                    (text_byte == ctt_pkg::CH_MINUS) || (text_byte == ctt_pkg::CH_DOT) ||
                    (text_byte == ctt_pkg::CH_US);
  assign num_ch   = ctt_pkg::is_digit(text_byte) || (text_byte == ctt_pkg::CH_DOT) ||
                    (text_byte == ctt_pkg::CH_PLUS) || (text_byte == ctt_pkg::CH_MINUS) ||
                    (text_byte == ctt_pkg::CH_LE) || (text_byte == ctt_pkg::CH_UE);

  // token start decode for a non-blank byte
  always_comb begin
    bk      = ctt_pkg::bracket_kind(text_byte);
    st_emit = 1'b0;
    st_setp = 1'b0;
    st_mode = ctt_pkg::MODE_LOOK;
    st_res  = ctt_pkg::mk_res(bk, 1'b1, text_byte, 1'b1, 1'b1);
    if (bk != ctt_pkg::TK_EOF) begin
      st_emit = 1'b1;
    end else if (ctt_pkg::is_letter(text_byte)) begin
      st_emit = 1'b1;
      st_res  = ctt_pkg::mk_res(ctt_pkg::TK_IDENT, 1'b1, text_byte, 1'b1, 1'b0);
      st_mode = ctt_pkg::MODE_IDENT;
    end else if (text_byte == ctt_pkg::CH_QUOTE) begin
      st_setp = 1'b1;
      st_mode = ctt_pkg::MODE_STRING;
    end else if (ctt_pkg::is_digit(text_byte) || (text_byte == ctt_pkg::CH_PLUS) ||
                 (text_byte == ctt_pkg::CH_MINUS)) begin
      st_emit = 1'b1;
      st_res  = ctt_pkg::mk_res(ctt_pkg::TK_NUMBER, 1'b1, text_byte, 1'b1, 1'b0);
      st_mode = ctt_pkg::MODE_NUMBER;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    bump     = 1'b0;
    e0_v     = 1'b0;
    e1_v     = 1'b0;
    r0       = st_res;
    r1       = ctt_pkg::mk_res(ctt_pkg::TK_EOF, 1'b0, 8'h00, 1'b1, 1'b1);
    if (kind) begin
      case (mode_r)
        ctt_pkg::MODE_HASH, ctt_pkg::MODE_HASHGT, ctt_pkg::MODE_COMMENT: begin
          bump = 1'b1;
          e0_v = 1'b1;
          r0   = r1;
        end
        ctt_pkg::MODE_IDENT: begin
          e0_v = 1'b1;
          e1_v = 1'b1;
          r0   = ctt_pkg::mk_res(ctt_pkg::TK_IDENT, 1'b0, 8'h00, 1'b0, 1'b1);
        end
        ctt_pkg::MODE_NUMBER: begin
          e0_v = 1'b1;
          e1_v = 1'b1;
          r0   = ctt_pkg::mk_res(ctt_pkg::TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1);
        end
        ctt_pkg::MODE_STRING: begin
          e0_v = 1'b1;
          e1_v = 1'b1;
          r0   = ctt_pkg::mk_res(ctt_pkg::TK_STRING, 1'b0, 8'h00, pend_r, 1'b1);
        end
        default: begin
          e0_v = 1'b1;
          r0   = r1;
        end
      endcase
      pend_nxt = 1'b0;
      mode_nxt = ctt_pkg::MODE_BLANK;
    end else begin
      case (mode_r)
        ctt_pkg::MODE_BLANK: begin
          bump = is_lf;
          if (text_byte == ctt_pkg::CH_HASH) begin
            mode_nxt = ctt_pkg::MODE_HASH;
          end else if (!is_blank) begin
            e0_v     = st_emit;
            mode_nxt = st_mode;
            pend_nxt = pend_r | st_setp;
          end
        end
        ctt_pkg::MODE_HASH, ctt_pkg::MODE_HASHGT, ctt_pkg::MODE_COMMENT: begin
          if ((mode_r != ctt_pkg::MODE_COMMENT) && (text_byte == ctt_pkg::CH_GT)) begin
            mode_nxt = (mode_r == ctt_pkg::MODE_HASH) ? ctt_pkg::MODE_HASHGT
                                                      : ctt_pkg::MODE_BLANK;
          end else if (is_lf) begin
            bump     = 1'b1;
            mode_nxt = ctt_pkg::MODE_BLANK;
          end else begin
            mode_nxt = ctt_pkg::MODE_COMMENT;
          end
        end
        ctt_pkg::MODE_IDENT, ctt_pkg::MODE_NUMBER: begin
          e0_v = 1'b1;
          if ((mode_r == ctt_pkg::MODE_IDENT) ? ident_ch : num_ch) begin
            r0 = ctt_pkg::mk_res((mode_r == ctt_pkg::MODE_IDENT) ? ctt_pkg::TK_IDENT
                                                                 : ctt_pkg::TK_NUMBER,
                                 1'b1, text_byte, 1'b0, 1'b0);
          end else begin
            r0       = ctt_pkg::mk_res((mode_r == ctt_pkg::MODE_IDENT) ? ctt_pkg::TK_IDENT
                                                                       : ctt_pkg::TK_NUMBER,
                                       1'b0, 8'h00, 1'b0, 1'b1);
            r1       = st_res;
            e1_v     = !is_blank && st_emit;
            bump     = is_lf;
            mode_nxt = is_blank ? ctt_pkg::MODE_BLANK : st_mode;
            pend_nxt = pend_r | (!is_blank && st_setp);
          end
        end
        ctt_pkg::MODE_STRING: begin
          e0_v     = 1'b1;
          pend_nxt = 1'b0;
          if (text_byte == ctt_pkg::CH_QUOTE) begin
            r0       = ctt_pkg::mk_res(ctt_pkg::TK_STRING, 1'b0, 8'h00, pend_r, 1'b1);
            mode_nxt = ctt_pkg::MODE_LOOK;
          end else begin
            r0   = ctt_pkg::mk_res(ctt_pkg::TK_STRING, 1'b1, text_byte, pend_r, 1'b0);
            bump = is_lf;
          end
        end
        default: begin
          bump     = is_lf;
          e0_v     = !is_blank && st_emit;
          mode_nxt = is_blank ? ctt_pkg::MODE_BLANK : st_mode;
          pend_nxt = pend_r | (!is_blank && st_setp);
        end
      endcase
    end
    r0.last = !e1_v;
    r1.last = 1'b1;
  end

  assign line_nxt = (bump && (line_r != {ctt_pkg::LINE_BITS{1'b1}}))
                  ? line_r + {{(ctt_pkg::LINE_BITS-1){1'b0}}, 1'b1} : line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctt_pkg::MODE_BLANK;
      pend_r <= 1'b0;
      line_r <= {{(ctt_pkg::LINE_BITS-1){1'b0}}, 1'b1};
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      line_r <= line_nxt;
    end
  end

  assign push       = e0_v;
  assign entry.two  = e1_v;
  assign entry.line = line_nxt;
  assign entry.r0   = r0;
  assign entry.r1   = r1;

endmodule

/* design/ctt_result_queue.sv */
// ----------------------------------------------------------------------------
// ctt_result_queue
// Two-entry queue of transaction result pairs, one result a cycle on out_ready.
// ----------------------------------------------------------------------------
module ctt_result_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  ctt_pkg::entry_t               push_entry,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctt_pkg::result_t              out_res,
  output logic [ctt_pkg::LINE_BITS-1:0] out_line
);

  ctt_pkg::entry_t                mem_r [ctt_pkg::QDEPTH];
  logic [ctt_pkg::QPTR_BITS-1:0]  wr_r, rd_r;
  logic [ctt_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           sub_r;
  ctt_pkg::entry_t                head;
  logic                           xfer;
  logic                           pop;

  assign head      = mem_r[rd_r];
  assign ready     = (cnt_r < ctt_pkg::QCNT_BITS'(ctt_pkg::QDEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_res   = sub_r ? head.r1 : head.r0;
  assign out_line  = head.line;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && (sub_r || !head.two);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (xfer) begin
        sub_r <= !pop;
      end
    end
  end

endmodule

/* design/config_text_tokenizer_unit.sv */
// Results of an accepted transaction are registered in the queue, then offered.
// One input per cycle if out_ready is high and each input yields one result or none;
// an input that yields two results sends them in turn from one queue entry.
// A two-entry result queue decouples the sides; input ready depends on its fill only.
// Reset (rst_n low, synchronous): blank mode, line count 1, queue empty.
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit
// Streaming tokenizer for configuration text, one byte or end of file per
// transaction, emitting token characters with kind, first and done marks.
// ----------------------------------------------------------------------------
module config_text_tokenizer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [7:0]                    in_text_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_token_kind,
  output logic                          out_has_char,
  output logic [7:0]                    out_token_char,
  output logic                          out_token_first,
  output logic                          out_token_done,
  output logic [ctt_pkg::LINE_BITS-1:0] out_line_number,
  output logic                          out_last_result
);

  logic             accept;
  logic             push;
  ctt_pkg::entry_t  entry;
  ctt_pkg::result_t res;

  assign accept = in_valid && in_ready;

  ctt_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_kind),
    .text_byte (in_text_byte),
    .push      (push),
    .entry     (entry)
  );

  ctt_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && push),
    .push_entry (entry),
    .ready      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res),
    .out_line   (out_line_number)
  );

  assign out_token_kind  = 4'(res.kind);
  assign out_has_char    = res.has_char;
  assign out_token_char  = res.ch;
  assign out_token_first = res.first;
  assign out_token_done  = res.done;
  assign out_last_result = res.last;

endmodule

/* design/ctt_checker.sv */
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic [7:0]                    in_text_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [3:0]                    out_token_kind,
  input logic                          out_has_char,
  input logic [7:0]                    out_token_char,
  input logic                          out_token_first,
  input logic                          out_token_done,
  input logic [ctt_pkg::LINE_BITS-1:0] out_line_number,
  input logic                          out_last_result
);

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_char) |-> (out_token_char == 8'h00))
    else $error("token_char set without a character");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == 4'(ctt_pkg::TK_EOF))) |->
      (out_token_first && out_token_done && out_last_result && !out_has_char))
    else $error("malformed end-of-file result");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_number != '0))
    else $error("line number is zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_token_kind) && $stable(out_token_char) &&
       $stable(out_line_number) && $stable(out_last_result)))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_kind) && $stable(in_text_byte)))
    else $error("stalled input transaction changed");

endmodule

bind config_text_tokenizer_unit ctt_checker u_ctt_checker (.*);

/* verif/config_text_tokenizer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit_tb
// Self-checking bench for the text tokenizer. A short table of hand-picked
// bytes and end-of-file marks runs first, then a long stream of generated
// text: identifiers, numbers, quoted strings, brackets, blanks, comments,
// stray bytes and end-of-file marks. Every accepted transaction goes through
// a behavioral tokenizer, and each token step that comes out of the block is
// compared field by field with the oldest predicted one. Both sides throttle
// at random, first one way, then the other, then not at all.
// ----------------------------------------------------------------------------
module config_text_tokenizer_unit_tb;

  localparam int   CLK_HALF     = 5;
  localparam int   CYCLE_LIMIT  = 300000;
  localparam int   RANDOM_ITEMS = 950;
  localparam logic IN_BYTE      = 1'b0;
  localparam logic IN_EOF       = 1'b1;

  typedef struct packed {
    ctt_pkg::tkind_t               kind;
    logic                          has_char;
    logic [7:0]                    ch;
    logic                          first;
    logic                          done;
    logic [ctt_pkg::LINE_BITS-1:0] line;
    logic                          last;
  } token_step_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] text;
  } text_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  text;
    logic        typed;
    logic [1:0]  n_typed;
    token_step_t r0;
    token_step_t r1;
  } lex_row_t;

  localparam token_step_t NO_STEP = '0;

  localparam lex_row_t LEX_ROWS [25] = '{
    '{IN_BYTE, "(",      1'b1, 2'd1,
      '{ctt_pkg::TK_LPAREN, 1'b1, "(", 1'b1, 1'b1, 24'd1, 1'b1}, NO_STEP},
    '{IN_EOF,  8'hFF,    1'b1, 2'd1,
      '{ctt_pkg::TK_EOF, 1'b0, 8'h00, 1'b1, 1'b1, 24'd1, 1'b1}, NO_STEP},
    '{IN_BYTE, 8'h00,             1'b1, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, 8'hFF,             1'b1, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_HASH,  1'b1, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_LF,    1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_HASH,  1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_GT,    1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_GT,    1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, "a",               1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_US,    1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_HASH,  1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_QUOTE, 1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_QUOTE, 1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_MINUS, 1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_UE,    1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_EOF,  8'h00,             1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_QUOTE, 1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, "x",               1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_EOF,  8'h5A,             1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, ctt_pkg::CH_HASH,  1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, "z",               1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_EOF,  8'hA5,             1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_EOF,  8'h00,             1'b0, 2'd0, NO_STEP, NO_STEP},
    '{IN_BYTE, "]",               1'b0, 2'd0, NO_STEP, NO_STEP}
  };

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          in_kind      = IN_BYTE;
  logic [7:0]                    in_text_byte = 8'h00;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic [3:0]                    out_token_kind;
  logic                          out_has_char;
  logic [7:0]                    out_token_char;
  logic                          out_token_first;
  logic                          out_token_done;
  logic [ctt_pkg::LINE_BITS-1:0] out_line_number;
  logic                          out_last_result;

  ctt_pkg::mode_t                lex_mode     = ctt_pkg::MODE_BLANK;
  logic [ctt_pkg::LINE_BITS-1:0] line_cnt     = ctt_pkg::LINE_BITS'(1);
  logic                          open_pending = 1'b0;
  token_step_t                   step_res[$];
  token_step_t                   token_q[$];
  text_item_t                    stim_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 30;
  int rx_idle_pct    = 65;

  config_text_tokenizer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_has_char    (out_has_char),
    .out_token_char  (out_token_char),
    .out_token_first (out_token_first),
    .out_token_done  (out_token_done),
    .out_line_number (out_line_number),
    .out_last_result (out_last_result)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic ctt_pkg::tkind_t bracket_of(input logic [7:0] c);
    case (c)
      "(":     return ctt_pkg::TK_LPAREN;
      ")":     return ctt_pkg::TK_RPAREN;
      "[":     return ctt_pkg::TK_LBRACK;
      "]":     return ctt_pkg::TK_RBRACK;
      "{":     return ctt_pkg::TK_LBRACE;
      "}":     return ctt_pkg::TK_RBRACE;
      "<":     return ctt_pkg::TK_LANGLE;
      ">":     return ctt_pkg::TK_RANGLE;
      default: return ctt_pkg::TK_EOF;
    endcase
  endfunction

  function automatic void bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void add_step(input ctt_pkg::tkind_t kind, input logic has,
                                   input logic [7:0] c, input logic first,
                                   input logic done);
    token_step_t s;
    if (step_res.size() >= 2) return;
    s          = '0;
    s.kind     = kind;
    s.has_char = has;
    s.ch       = has ? c : 8'h00;
    s.first    = first;
    s.done     = done;
    step_res.push_back(s);
  endfunction

  function automatic void open_token(input logic [7:0] c);
    ctt_pkg::tkind_t bk;
    bk = bracket_of(c);
    if (bk != ctt_pkg::TK_EOF) begin
      add_step(bk, 1'b1, c, 1'b1, 1'b1);
      lex_mode = ctt_pkg::MODE_LOOK;
    end else if (alpha_char(c)) begin
      add_step(ctt_pkg::TK_IDENT, 1'b1, c, 1'b1, 1'b0);
      lex_mode = ctt_pkg::MODE_IDENT;
    end else if (c == ctt_pkg::CH_QUOTE) begin
      open_pending = 1'b1;
      lex_mode     = ctt_pkg::MODE_STRING;
    end else if (digit_char(c) || (c == ctt_pkg::CH_PLUS) || (c == ctt_pkg::CH_MINUS)) begin
      add_step(ctt_pkg::TK_NUMBER, 1'b1, c, 1'b1, 1'b0);
      lex_mode = ctt_pkg::MODE_NUMBER;
    end else begin
      lex_mode = ctt_pkg::MODE_LOOK;
    end
  endfunction

  function automatic void after_token(input logic [7:0] c);
    if (c == ctt_pkg::CH_LF) bump_line();
    if (c <= ctt_pkg::CH_SPACE) lex_mode = ctt_pkg::MODE_BLANK;
    else open_token(c);
  endfunction

  function automatic void comment_char(input logic [7:0] c);
    if (c == ctt_pkg::CH_LF) begin
      bump_line();
      lex_mode = ctt_pkg::MODE_BLANK;
    end else begin
      lex_mode = ctt_pkg::MODE_COMMENT;
    end
  endfunction

  function automatic void tokenize_item(input logic k, input logic [7:0] c);
    step_res.delete();
    if (k == IN_EOF) begin
      case (lex_mode)
        ctt_pkg::MODE_HASH, ctt_pkg::MODE_HASHGT, ctt_pkg::MODE_COMMENT: bump_line();
        ctt_pkg::MODE_IDENT:  add_step(ctt_pkg::TK_IDENT, 1'b0, 8'h00, 1'b0, 1'b1);
        ctt_pkg::MODE_NUMBER: add_step(ctt_pkg::TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1);
        ctt_pkg::MODE_STRING: add_step(ctt_pkg::TK_STRING, 1'b0, 8'h00, open_pending, 1'b1);
        default: ;
      endcase
      add_step(ctt_pkg::TK_EOF, 1'b0, 8'h00, 1'b1, 1'b1);
      open_pending = 1'b0;
      lex_mode     = ctt_pkg::MODE_BLANK;
    end else begin
      case (lex_mode)
        ctt_pkg::MODE_BLANK: begin
          if (c == ctt_pkg::CH_LF) bump_line();
          if (c == ctt_pkg::CH_HASH) lex_mode = ctt_pkg::MODE_HASH;
          else if (c > ctt_pkg::CH_SPACE) open_token(c);
        end
        ctt_pkg::MODE_HASH: begin
          if (c == ctt_pkg::CH_GT) lex_mode = ctt_pkg::MODE_HASHGT;
          else comment_char(c);
        end
        ctt_pkg::MODE_HASHGT: begin
          if (c == ctt_pkg::CH_GT) lex_mode = ctt_pkg::MODE_BLANK;
          else comment_char(c);
        end
        ctt_pkg::MODE_COMMENT: comment_char(c);
        ctt_pkg::MODE_IDENT: begin
          if (alpha_char(c) || digit_char(c) || (c == ctt_pkg::CH_MINUS) ||
              (c == ctt_pkg::CH_DOT) || (c == ctt_pkg::CH_US)) begin
            add_step(ctt_pkg::TK_IDENT, 1'b1, c, 1'b0, 1'b0);
          end else begin
            add_step(ctt_pkg::TK_IDENT, 1'b0, 8'h00, 1'b0, 1'b1);
            after_token(c);
          end
        end
        ctt_pkg::MODE_NUMBER: begin
          if (digit_char(c) || (c == ctt_pkg::CH_DOT) || (c == ctt_pkg::CH_PLUS) ||
              (c == ctt_pkg::CH_MINUS) || (c == ctt_pkg::CH_LE) ||
              (c == ctt_pkg::CH_UE)) begin
            add_step(ctt_pkg::TK_NUMBER, 1'b1, c, 1'b0, 1'b0);
          end else begin
            add_step(ctt_pkg::TK_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1);
            after_token(c);
          end
        end
        ctt_pkg::MODE_STRING: begin
          if (c == ctt_pkg::CH_QUOTE) begin
            add_step(ctt_pkg::TK_STRING, 1'b0, 8'h00, open_pending, 1'b1);
            open_pending = 1'b0;
            lex_mode     = ctt_pkg::MODE_LOOK;
          end else begin
            if (c == ctt_pkg::CH_LF) bump_line();
            add_step(ctt_pkg::TK_STRING, 1'b1, c, open_pending, 1'b0);
            open_pending = 1'b0;
          end
        end
        default: after_token(c);
      endcase
    end
    foreach (step_res[i]) begin
      step_res[i].line = line_cnt;
      step_res[i].last = (i == step_res.size() - 1);
    end
  endfunction

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) == 0) return 8'h41 + 8'($urandom_range(0, 25));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic int text_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic void put_byte(input logic [7:0] c);
    stim_q.push_back('{IN_BYTE, c});
  endfunction

  function automatic void gen_fragment();
    string      brackets;
    int         sel;
    int         len;
    logic [7:0] c;
    brackets = "()[]{}<>";
    sel      = $urandom_range(0, 99);
    len      = text_len();
    if (sel < 20) begin
      put_byte(any_letter());
      repeat (len) begin
        case ($urandom_range(0, 4))
          0:       c = any_letter();
          1:       c = any_digit();
          2:       c = ctt_pkg::CH_MINUS;
          3:       c = ctt_pkg::CH_DOT;
          default: c = ctt_pkg::CH_US;
        endcase
        put_byte(c);
      end
    end else if (sel < 32) begin
      case ($urandom_range(0, 3))
        0:       put_byte(ctt_pkg::CH_PLUS);
        1:       put_byte(ctt_pkg::CH_MINUS);
        default: put_byte(any_digit());
      endcase
      repeat (len) begin
        case ($urandom_range(0, 7))
          0:       c = ctt_pkg::CH_DOT;
          1:       c = ctt_pkg::CH_PLUS;
          2:       c = ctt_pkg::CH_MINUS;
          3:       c = ctt_pkg::CH_LE;
          4:       c = ctt_pkg::CH_UE;
          default: c = any_digit();
        endcase
        put_byte(c);
      end
    end else if (sel < 44) begin
      put_byte(ctt_pkg::CH_QUOTE);
      repeat (len) begin
        c = 8'($urandom_range(0, 255));
        if (c == ctt_pkg::CH_QUOTE || $urandom_range(0, 9) == 0) c = ctt_pkg::CH_LF;
        put_byte(c);
      end
      if ($urandom_range(0, 9) != 0) put_byte(ctt_pkg::CH_QUOTE);
    end else if (sel < 56) begin
      put_byte(brackets[$urandom_range(0, 7)]);
    end else if (sel < 72) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) put_byte(ctt_pkg::CH_LF);
        else put_byte(8'($urandom_range(0, 32)));
      end
    end else if (sel < 80) begin
      put_byte(ctt_pkg::CH_SPACE);
      put_byte(ctt_pkg::CH_HASH);
      repeat (len) begin
        c = 8'($urandom_range(0, 255));
        if (c == ctt_pkg::CH_LF) c = ctt_pkg::CH_GT;
        put_byte(c);
      end
      put_byte(ctt_pkg::CH_LF);
    end else if (sel < 85) begin
      put_byte(ctt_pkg::CH_SPACE);
      put_byte(ctt_pkg::CH_HASH);
      put_byte(ctt_pkg::CH_GT);
      put_byte(($urandom_range(0, 3) == 0) ? any_letter() : ctt_pkg::CH_GT);
    end else if (sel < 88) begin
      stim_q.push_back('{IN_EOF, 8'($urandom_range(0, 255))});
    end else begin
      repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_text(input logic k, input logic [7:0] c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_text_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_item(k, c);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    token_step_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        flag_mismatch("token step with nothing outstanding");
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 32'(out_token_kind), 32'(want.kind));
        check_field("has_char", 32'(out_has_char), 32'(want.has_char));
        check_field("token_char", 32'(out_token_char), 32'(want.ch));
        check_field("token_first", 32'(out_token_first), 32'(want.first));
        check_field("token_done", 32'(out_token_done), 32'(want.done));
        check_field("line_number", 32'(out_line_number), 32'(want.line));
        check_field("last_result", 32'(out_last_result), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[config_text_tokenizer_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (LEX_ROWS[i]) begin
      send_text(LEX_ROWS[i].kind, LEX_ROWS[i].text);
      if (LEX_ROWS[i].typed) begin
        if (LEX_ROWS[i].n_typed > 0) token_q.push_back(LEX_ROWS[i].r0);
        if (LEX_ROWS[i].n_typed > 1) token_q.push_back(LEX_ROWS[i].r1);
      end else begin
        foreach (step_res[j]) token_q.push_back(step_res[j]);
      end
    end

    while (stim_q.size() < RANDOM_ITEMS) gen_fragment();
    n = stim_q.size();
    foreach (stim_q[i]) begin
      if (i == n / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 30;
      end else if (i == (2 * n) / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_text(stim_q[i].kind, stim_q[i].text);
      foreach (step_res[j]) token_q.push_back(step_res[j]);
    end
    in_valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[config_text_tokenizer_unit] OK");
    end else begin
      $display("[config_text_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ctt_pkg.sv
design/ctt_lexer.sv
design/ctt_result_queue.sv
design/config_text_tokenizer_unit.sv
design/ctt_checker.sv
verif/config_text_tokenizer_unit_tb.sv
